// ===== hw/rtl/pointer_log_safety_query_unit_assert.svh =====
// Assertion macros used by the checker file of the pointer log query unit.
// Holds macro definitions only.
`ifndef POINTER_LOG_SAFETY_QUERY_UNIT_ASSERT_SVH
`define POINTER_LOG_SAFETY_QUERY_UNIT_ASSERT_SVH

// Assert an implication on the rising clock edge, off during reset.
`define PLQ_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Assert an implication whose consequent is checked in the cycle after the antecedent.
`define PLQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/plq_pkg.sv =====
// Package for the pointer log safety query unit: widths, action codes, types.
// No dependencies.
`default_nettype none
package plq_pkg;
    localparam int unsigned LogDepth = 256;
    localparam int unsigned CntW = $clog2(LogDepth + 1);
    localparam int unsigned AddrW = 64;

    localparam logic [2:0] ACT_APPEND  = 3'd0;
    localparam logic [2:0] ACT_OLD_REF = 3'd1;
    localparam logic [2:0] ACT_CLEANUP = 3'd2;
    localparam logic [2:0] ACT_DEREF   = 3'd3;
    localparam logic [2:0] ACT_FREE    = 3'd4;

    typedef struct packed {
        logic [AddrW-1:0] addr;
        logic [AddrW-1:0] tgt;
        logic             freed;
        logic             dyn;
    } entry_t;

    // Token that flows down the chain, oldest cell to newest.
    // Cells at or above lim let it pass untouched.
    typedef struct packed {
        logic             live;
        logic [2:0]       op;
        logic [AddrW-1:0] key;
        logic [CntW-1:0]  lim;
        logic [AddrW-1:0] tgt;
        logic             verdict;
        logic             ovf;
    } token_t;
endpackage
`default_nettype wire

// ===== hw/rtl/plq_cell.sv =====
// One log cell: holds an entry, updates the passing token and hands it to
// its newer neighbor. Depends on plq_pkg.
`default_nettype none
module plq_cell (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     wr_en,
    input  wire plq_pkg::entry_t          wr_entry,
    input  wire logic [plq_pkg::CntW-1:0] idx,
    input  wire plq_pkg::token_t          tok_in,
    output plq_pkg::token_t               tok_out
);
    plq_pkg::entry_t entry_reg;
    // set once a newer entry reassigns the same pointer
    logic            sup_reg;
    plq_pkg::token_t tok_reg, tok_next;
    logic            hit, addr_eq, tgt_eq, bad;

    assign hit     = tok_in.live && (idx < tok_in.lim);
    assign addr_eq = (entry_reg.addr == tok_in.key);
    assign tgt_eq  = (entry_reg.tgt == tok_in.key);
    assign bad     = entry_reg.freed || !entry_reg.dyn;

    // Newer cells come later, so a later match overrides an older one.
    always_comb begin
        tok_next = tok_in;
        if (hit) begin
            case (tok_in.op)
                plq_pkg::ACT_OLD_REF: begin
                    if (addr_eq) begin
                        tok_next.tgt = entry_reg.tgt;
                    end
                end
                plq_pkg::ACT_CLEANUP: begin
                    if (tgt_eq && !sup_reg) begin
                        tok_next.verdict = 1'b1;
                    end
                end
                plq_pkg::ACT_DEREF: begin
                    if (addr_eq) begin
                        tok_next.verdict = 1'b0;
                    end else if (tgt_eq) begin
                        tok_next.verdict = bad;
                    end
                end
                plq_pkg::ACT_FREE: begin
                    if (tgt_eq) begin
                        tok_next.verdict = bad;
                    end
                end
                default: tok_next = tok_in;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_reg <= wr_entry;
            sup_reg   <= 1'b0;
        end else if (hit && tok_in.op == plq_pkg::ACT_APPEND && addr_eq) begin
            sup_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/pointer_log_safety_query_unit.sv =====
// Pointer log safety query unit: an append-only log of 256 pointer
// assignments kept in a row of cells. Every request, append or query, sends
// one token through all 256 cells, one cell a cycle, oldest to newest; each
// cell folds its entry into the token. The result is registered from the
// token leaving the newest cell and shows on m_tvalid, whatever the action or
// fill level. One request is in flight at a time: the next is accepted the
// cycle after the result is taken.
// Depends on plq_pkg and plq_cell.
`default_nettype none
module pointer_log_safety_query_unit (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // action[2:0], address[66:3], target[130:67], dynamic_mark[131],
    // freed_mark[132], zero pad to 136
    input  wire logic [135:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // reference[63:0], verdict[64], overflow[65], zero pad to 72
    output logic [71:0]       m_tdata
);
    localparam int unsigned N = plq_pkg::LogDepth;
    localparam int unsigned CW = plq_pkg::CntW;
    localparam int unsigned AW = plq_pkg::AddrW;

    logic            busy_reg;
    logic [CW-1:0]   count_reg;
    plq_pkg::token_t inj_reg, inj_next;
    logic [AW-1:0]   res_ref_reg;
    logic            res_verdict_reg, res_ovf_reg;
    logic            out_valid_reg;

    plq_pkg::entry_t wr_entry;
    logic [N-1:0]    wr_en;
    plq_pkg::token_t toks [N];
    plq_pkg::token_t tail;

    logic [2:0]    in_act;
    logic [AW-1:0] in_addr;
    logic          accept;

    assign in_act  = s_tdata[2:0];
    assign in_addr = s_tdata[66:3];
    assign wr_entry.addr  = s_tdata[66:3];
    assign wr_entry.tgt   = s_tdata[130:67];
    assign wr_entry.dyn   = s_tdata[131];
    assign wr_entry.freed = s_tdata[132];

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;

    // Build the token for an accepted request; lim of zero lets it pass all cells.
    always_comb begin
        inj_next = '0;
        if (accept) begin
            inj_next.live = 1'b1;
            inj_next.op   = in_act;
            inj_next.key  = in_addr;
            inj_next.lim  = count_reg;
            case (in_act)
                plq_pkg::ACT_APPEND: begin
                    if (count_reg == CW'(N)) begin
                        inj_next.lim = '0;
                        inj_next.ovf = 1'b1;
                    end
                end
                plq_pkg::ACT_OLD_REF, plq_pkg::ACT_CLEANUP: begin
                    inj_next.verdict = 1'b0;
                end
                plq_pkg::ACT_DEREF: begin
                    inj_next.verdict = 1'b1;
                end
                plq_pkg::ACT_FREE: begin
                    inj_next.verdict = (in_addr != '0);
                    if (in_addr == '0) begin
                        inj_next.lim = '0;
                    end
                end
                default: inj_next.lim = '0;
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            plq_pkg::token_t tin;
            if (g == 0) begin : g_head
                assign tin = inj_reg;
            end else begin : g_link
                assign tin = toks[g-1];
            end
            assign wr_en[g] = accept && (in_act == plq_pkg::ACT_APPEND)
                              && (count_reg == CW'(g));
            plq_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .wr_en   (wr_en[g]),
                .wr_entry(wr_entry),
                .idx     (CW'(g)),
                .tok_in  (tin),
                .tok_out (toks[g])
            );
        end
    endgenerate

    assign tail = toks[N-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg        <= 1'b0;
            count_reg       <= '0;
            inj_reg         <= '0;
            out_valid_reg   <= 1'b0;
            res_ref_reg     <= '0;
            res_verdict_reg <= 1'b0;
            res_ovf_reg     <= 1'b0;
        end else begin
            inj_reg <= inj_next;
            if (accept) begin
                busy_reg <= 1'b1;
                if (in_act == plq_pkg::ACT_APPEND && count_reg != CW'(N)) begin
                    count_reg <= count_reg + CW'(1);
                end
            end
            // hold the result until taken, then free the input side
            if (tail.live) begin
                out_valid_reg   <= 1'b1;
                res_ref_reg     <= tail.tgt;
                res_verdict_reg <= tail.verdict;
                res_ovf_reg     <= tail.ovf;
            end else if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
                busy_reg      <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, res_ovf_reg, res_verdict_reg, res_ref_reg};
endmodule
`default_nettype wire

// ===== hw/rtl/plq_checker.sv =====
// Port-level checker for the pointer log safety query unit, bound to the top.
// Depends on pointer_log_safety_query_unit_assert.svh.
`default_nettype none
`include "pointer_log_safety_query_unit_assert.svh"
module plq_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [71:0]  m_tdata
);
    // no new request while a result waits
    `PLQ_ASSERT_IMP(a_no_take_while_out, aclk, aresetn, m_tvalid, !s_tready)
    // result held while stalled
    `PLQ_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    // result data held while stalled
    `PLQ_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))
    // one request in flight at a time
    `PLQ_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // overflow only flagged with empty reference and verdict
    `PLQ_ASSERT_IMP(a_ovf_clean, aclk, aresetn, m_tvalid && m_tdata[65], m_tdata[64] == 1'b0 && m_tdata[63:0] == 64'd0)
endmodule
bind pointer_log_safety_query_unit plq_checker u_plq_checker (.*);
`default_nettype wire

// ===== verif/pointer_log_safety_query_unit_tb.sv =====
// Self-checking testbench for pointer_log_safety_query_unit: drives append and
// query requests on the input stream and checks every result against its own log model.
// Depends on plq_pkg and the RTL of the unit.
`default_nettype none
module pointer_log_safety_query_unit_tb;
    localparam int unsigned CycleLimit = 6000000;
    localparam int unsigned PoolSize = 16;

    typedef struct packed {
        logic [2:0]                action;
        logic [plq_pkg::AddrW-1:0] address;
        logic [plq_pkg::AddrW-1:0] target;
        logic                      dyn;
        logic                      freed;
    } request_t;

    typedef struct packed {
        logic [plq_pkg::AddrW-1:0] reference;
        logic                      verdict;
        logic                      overflow;
    } answer_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;

    // Model of the log
    logic [plq_pkg::AddrW-1:0] log_addr [plq_pkg::LogDepth];
    logic [plq_pkg::AddrW-1:0] log_tgt [plq_pkg::LogDepth];
    logic                      log_freed [plq_pkg::LogDepth];
    logic                      log_dyn [plq_pkg::LogDepth];
    int unsigned               log_count;

    answer_t                   pending_answers[$];
    logic [plq_pkg::AddrW-1:0] addr_pool [PoolSize];
    logic [plq_pkg::AddrW-1:0] tgt_pool [PoolSize];
    int unsigned               send_idle_pct;
    int unsigned               recv_stall_pct;
    int unsigned               mismatches;
    int unsigned               cycles;

    pointer_log_safety_query_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    function automatic logic misuse_verdict(int unsigned i);
        return log_freed[i] || !log_dyn[i];
    endfunction

    // Apply one request to the log and return the answer it must give.
    function automatic answer_t apply_request(request_t rq);
        answer_t ans;
        logic    still;
        logic    found;
        ans = '0;
        found = 1'b0;
        case (rq.action)
            plq_pkg::ACT_APPEND: begin
                if (log_count < plq_pkg::LogDepth) begin
                    log_addr[log_count] = rq.address;
                    log_tgt[log_count] = rq.target;
                    log_freed[log_count] = rq.freed;
                    log_dyn[log_count] = rq.dyn;
                    log_count++;
                end else begin
                    ans.overflow = 1'b1;
                end
            end
            plq_pkg::ACT_OLD_REF: begin
                for (int i = int'(log_count) - 1; i >= 0 && !found; i--) begin
                    if (log_addr[i] == rq.address) begin
                        ans.reference = log_tgt[i];
                        found = 1'b1;
                    end
                end
            end
            plq_pkg::ACT_CLEANUP: begin
                for (int i = int'(log_count) - 1; i >= 0 && !found; i--) begin
                    if (log_tgt[i] == rq.address) begin
                        still = 1'b1;
                        for (int j = int'(log_count) - 1; j > i; j--) begin
                            if (log_addr[j] == log_addr[i]) begin
                                still = (log_tgt[j] == rq.address);
                                break;
                            end
                        end
                        if (still) begin
                            ans.verdict = 1'b1;
                            found = 1'b1;
                        end
                    end
                end
            end
            plq_pkg::ACT_DEREF: begin
                ans.verdict = 1'b1;
                for (int i = int'(log_count) - 1; i >= 0 && !found; i--) begin
                    if (log_addr[i] == rq.address) begin
                        ans.verdict = 1'b0;
                        found = 1'b1;
                    end else if (log_tgt[i] == rq.address) begin
                        ans.verdict = misuse_verdict(i);
                        found = 1'b1;
                    end
                end
            end
            plq_pkg::ACT_FREE: begin
                ans.verdict = (rq.address != '0);
                for (int i = int'(log_count) - 1; i >= 0 && !found && rq.address != '0;
                     i--) begin
                    if (log_tgt[i] == rq.address) begin
                        ans.verdict = misuse_verdict(i);
                        found = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return ans;
    endfunction

    // Drive one request, with random idle cycles ahead of it.
    task automatic send_request(request_t rq);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, rq.freed, rq.dyn, rq.target, rq.address, rq.action};
        do @(posedge aclk); while (!s_tready);
        pending_answers.push_back(apply_request(rq));
    endtask

    task automatic hold_until_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
    endtask

    function automatic request_t make_req(logic [2:0] act, logic [plq_pkg::AddrW-1:0] a,
                                          logic [plq_pkg::AddrW-1:0] t, logic d, logic f);
        request_t rq;
        rq.action = act;
        rq.address = a;
        rq.target = t;
        rq.dyn = d;
        rq.freed = f;
        return rq;
    endfunction

    function automatic logic [plq_pkg::AddrW-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [plq_pkg::AddrW-1:0] pick_address();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40) return addr_pool[$urandom_range(PoolSize - 1)];
        if (r < 75) return tgt_pool[$urandom_range(PoolSize - 1)];
        if (r < 82) return '0;
        return rand_word();
    endfunction

    function automatic request_t random_request();
        request_t    rq;
        int unsigned r;
        rq.address = pick_address();
        rq.target = ($urandom_range(99) < 75) ? tgt_pool[$urandom_range(PoolSize - 1)]
                                              : rand_word();
        rq.dyn = 1'($urandom_range(1));
        rq.freed = 1'($urandom_range(1));
        r = $urandom_range(99);
        if (r < 35)      rq.action = plq_pkg::ACT_APPEND;
        else if (r < 47) rq.action = plq_pkg::ACT_OLD_REF;
        else if (r < 55) rq.action = plq_pkg::ACT_CLEANUP;
        else if (r < 74) rq.action = plq_pkg::ACT_DEREF;
        else if (r < 95) rq.action = plq_pkg::ACT_FREE;
        else             rq.action = 3'($urandom_range(5, 7));
        return rq;
    endfunction

    task automatic test_empty_log();
        logic [plq_pkg::AddrW-1:0] x;
        x = rand_word();
        send_request(make_req(plq_pkg::ACT_OLD_REF, x, '0, 1'b0, 1'b0));
        send_request(make_req(plq_pkg::ACT_CLEANUP, x, '0, 1'b0, 1'b0));
        send_request(make_req(plq_pkg::ACT_DEREF, x, '0, 1'b0, 1'b0));
        send_request(make_req(plq_pkg::ACT_FREE, '0, '0, 1'b0, 1'b0));
        send_request(make_req(plq_pkg::ACT_FREE, x, '1, 1'b1, 1'b1));
        for (int a = 5; a <= 7; a++) send_request(make_req(3'(a), '1, '1, 1'b1, 1'b1));
    endtask

    task automatic test_directed_entries();
        logic [plq_pkg::AddrW-1:0] pa, pb, t, u;
        pa = addr_pool[0];
        pb = addr_pool[1];
        t = tgt_pool[0];
        u = tgt_pool[1];
        send_request(make_req(plq_pkg::ACT_APPEND, pa, t, 1'b1, 1'b0));
        send_request(make_req(plq_pkg::ACT_APPEND, pb, t, 1'b1, 1'b1));
        send_request(make_req(plq_pkg::ACT_DEREF, t, '0, 1'b0, 1'b0));
        send_request(make_req(plq_pkg::ACT_FREE, t, '0, 1'b0, 1'b0));
        send_request(make_req(plq_pkg::ACT_CLEANUP, t, '0, 1'b0, 1'b0));
        send_request(make_req(plq_pkg::ACT_APPEND, pb, u, 1'b1, 1'b0));
        send_request(make_req(plq_pkg::ACT_CLEANUP, t, '0, 1'b0, 1'b0));
        send_request(make_req(plq_pkg::ACT_OLD_REF, pb, '0, 1'b0, 1'b0));
        // own address met before any target: deref answers false
        send_request(make_req(plq_pkg::ACT_DEREF, pa, '0, 1'b0, 1'b0));
        send_request(make_req(plq_pkg::ACT_APPEND, '1, '1, 1'b0, 1'b0));
        send_request(make_req(plq_pkg::ACT_APPEND, '0, '0, 1'b1, 1'b0));
        send_request(make_req(plq_pkg::ACT_OLD_REF, '1, '0, 1'b0, 1'b0));
        send_request(make_req(plq_pkg::ACT_FREE, '1, '0, 1'b0, 1'b0));
        send_request(make_req(plq_pkg::ACT_FREE, '0, '0, 1'b0, 1'b0));
        send_request(make_req(plq_pkg::ACT_DEREF, '0, '0, 1'b0, 1'b0));
    endtask

    task automatic test_random_phase(int unsigned n, int unsigned idle, int unsigned stall);
        hold_until_drained();
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (n) send_request(random_request());
    endtask

    // Stall the result side at random.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        answer_t got;
        answer_t want;
        got.reference = m_tdata[63:0];
        got.verdict = m_tdata[64];
        got.overflow = m_tdata[65];
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_tdata);
            end else begin
                want = pending_answers.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: ref %h/%h verdict %b/%b overflow %b/%b",
                                 want.reference, got.reference, want.verdict,
                                 got.verdict, want.overflow, got.overflow);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        log_count = 0;
        mismatches = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < PoolSize; i++) begin
            addr_pool[i] = rand_word();
            tgt_pool[i] = rand_word();
        end
        // share a few values so pointers also appear as targets
        tgt_pool[PoolSize - 1] = addr_pool[2];
        tgt_pool[PoolSize - 2] = addr_pool[3];
        tgt_pool[PoolSize - 3] = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_log();
        test_directed_entries();
        test_random_phase(280, 0, 0);
        test_random_phase(270, 55, 0);
        test_random_phase(270, 0, 55);
        test_random_phase(270, 9, 9);
        test_random_phase(30, 0, 0);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire
